### rtl/jsce_pkg.sv
// shared constants and codes for the jacobi stencil block
package jsce_pkg;

  localparam int DEF_MAX_COLS    = 1024;
  localparam int DEF_SAMPLE_BITS = 16;

  localparam int CFG_COLS_W = 11;
  localparam int CFG_ROWS_W = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'd1;

  localparam logic [CFG_COLS_W-1:0] GRID_COLS_RST = 11'd1024;
  localparam logic [CFG_ROWS_W-1:0] GRID_ROWS_RST = 13'd1024;

  localparam logic REQ_CELL  = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

endpackage

### rtl/jacobi_stencil_clamped_edges.sv
// jacobi four-neighbor sweep with replicated edges over a raster-order grid
// latency: a result is registered at the edge that accepts its request, into the output
//   register that drives m_tvalid, or into the skid while an earlier result waits
// throughput: one request per cycle while s_tready is high; the newer line-store ram is read
//   one column ahead of the request stream and the older one at the current column
// a two-entry output (register plus skid) keeps s_tready high while one result waits
// reset: synchronous, active high; clears counters, store select and valid flags and
//   loads grid_cols and grid_rows with 1024; line stores are not cleared
module jacobi_stencil_clamped_edges
  import jsce_pkg::*;
#(
  parameter int MAX_COLS    = DEF_MAX_COLS,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  localparam int TDATA_W    = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  // request stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [TDATA_W-1:0]    s_tdata,   // sample (signed q8.8), zero padded
  input  logic                  s_tuser,   // req_type: cell or drain tick
  // result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [TDATA_W-1:0]    m_tdata,   // value (signed q8.8), zero padded
  output logic                  m_tlast,   // row_end
  output logic                  m_tuser,   // frame_end
  // register writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int ADDR_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CW     = ($clog2(MAX_COLS + 1) > CFG_COLS_W) ? $clog2(MAX_COLS + 1)
                                                              : CFG_COLS_W;
  localparam int SUM_W  = SAMPLE_BITS + 2;

  // configuration registers
  logic [CFG_COLS_W-1:0] grid_cols;
  logic [CFG_ROWS_W-1:0] grid_rows;

  // sweep position
  logic [CFG_ROWS_W-1:0] row_index, row_index_next;
  logic [ADDR_W-1:0]     col_index, col_index_next;
  logic                  store_select, store_select_next;

  // neighbor window over the newer row
  logic [SAMPLE_BITS-1:0] win_left;    // newer row, column c-1
  logic [SAMPLE_BITS-1:0] win_self;    // newer row, column c
  logic [SAMPLE_BITS-1:0] hold_n0;     // newer row, column 0
  logic [SAMPLE_BITS-1:0] pend_n0;     // column 0 of the row being written
  logic                   fwd_hit;     // ram read collided with last write
  logic [SAMPLE_BITS-1:0] fwd_data;

  // output register and skid
  logic                   out_valid, skid_valid;
  logic [SAMPLE_BITS-1:0] out_value, skid_value;
  logic                   out_row_end, skid_row_end;
  logic                   out_frame_end, skid_frame_end;

  // ram ports
  logic                   we0, we1;
  logic [ADDR_W-1:0]      raddr0, raddr1;
  logic [SAMPLE_BITS-1:0] rd0, rd1;
  logic [ADDR_W-1:0]      col_next_p1;

  // step decode
  logic [CW-1:0]          cols_ext, cols_eff;
  logic [CFG_ROWS_W-1:0]  rows_eff;
  logic                   last_col, col_first, drain_phase, req_drain;
  logic                   accept, step, cell_step, emit;
  logic [SAMPLE_BITS-1:0] sample;

  // stencil datapath
  logic [SAMPLE_BITS-1:0] newer_rd, older_rd, right_rd;
  logic [SAMPLE_BITS-1:0] self_v, left_v, right_v, up_v, down_v;
  logic [SUM_W-1:0]       bias_sum;
  logic [SAMPLE_BITS-1:0] mean_b, res_value;
  logic                   res_frame_end;

  assign cfg_ready = 1'b1;
  assign s_tready  = !skid_valid;

  // effective grid size: zero counts as one, width capped at the store depth
  assign cols_ext = CW'(grid_cols);
  always_comb begin
    if (grid_cols == '0) begin
      cols_eff = CW'(1);
    end else if (cols_ext > CW'(MAX_COLS)) begin
      cols_eff = CW'(MAX_COLS);
    end else begin
      cols_eff = cols_ext;
    end
  end
  assign rows_eff = (grid_rows == '0) ? CFG_ROWS_W'(1) : grid_rows;

  assign last_col    = (CW'(col_index) + CW'(1)) >= cols_eff;
  assign col_first   = (col_index == '0);
  assign drain_phase = (row_index >= rows_eff);
  assign req_drain   = (s_tuser == REQ_DRAIN);
  assign sample      = s_tdata[SAMPLE_BITS-1:0];

  // cells are taken before the drain phase, drain ticks only during it;
  // anything else is swallowed without a result
  assign accept    = s_tvalid && s_tready;
  assign step      = accept && (req_drain == drain_phase);
  assign cell_step = step && !req_drain;
  // the first row only fills the stores
  assign emit      = step && (req_drain || (row_index != '0));

  // store_select low: ram1 holds the newer row, ram0 the older one
  assign newer_rd = store_select ? rd0 : rd1;
  assign older_rd = store_select ? rd1 : rd0;
  assign right_rd = fwd_hit ? fwd_data : newer_rd;

  // edge replication: an off-grid neighbor is the cell itself
  assign self_v  = col_first ? hold_n0 : win_self;
  assign left_v  = col_first ? self_v : win_left;
  assign right_v = last_col ? self_v : right_rd;
  assign up_v    = (row_index >= CFG_ROWS_W'(2)) ? older_rd : self_v;
  assign down_v  = req_drain ? self_v : sample;

  // floor of the mean: sum in offset binary, drop two bits, restore the sign
  assign bias_sum = SUM_W'({~up_v[SAMPLE_BITS-1], up_v[SAMPLE_BITS-2:0]})
                  + SUM_W'({~down_v[SAMPLE_BITS-1], down_v[SAMPLE_BITS-2:0]})
                  + SUM_W'({~left_v[SAMPLE_BITS-1], left_v[SAMPLE_BITS-2:0]})
                  + SUM_W'({~right_v[SAMPLE_BITS-1], right_v[SAMPLE_BITS-2:0]});
  assign mean_b    = bias_sum[SUM_W-1:2];
  assign res_value = {~mean_b[SAMPLE_BITS-1], mean_b[SAMPLE_BITS-2:0]};
  assign res_frame_end = req_drain && last_col;

  // next sweep position
  always_comb begin
    row_index_next    = row_index;
    col_index_next    = col_index;
    store_select_next = store_select;
    if (step) begin
      if (last_col) begin
        col_index_next = '0;
        if (req_drain) begin
          // end of drain starts a new frame
          row_index_next = '0;
        end else begin
          row_index_next    = row_index + CFG_ROWS_W'(1);
          store_select_next = ~store_select;
        end
      end else begin
        col_index_next = col_index + ADDR_W'(1);
      end
    end
  end

  // reads run one step ahead: newer row at column c+1, older row at column c
  assign col_next_p1 = col_index_next + ADDR_W'(1);
  assign raddr0 = store_select_next ? col_next_p1 : col_index_next;
  assign raddr1 = store_select_next ? col_index_next : col_next_p1;

  // cells land in the older store, which turns newer at the row end
  assign we0 = cell_step && !store_select;
  assign we1 = cell_step && store_select;

  jsce_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_COLS)
  ) u_store0 (
    .clk   (clk),
    .we    (we0),
    .waddr (col_index),
    .wdata (sample),
    .raddr (raddr0),
    .rdata (rd0)
  );

  jsce_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_COLS)
  ) u_store1 (
    .clk   (clk),
    .we    (we1),
    .waddr (col_index),
    .wdata (sample),
    .raddr (raddr1),
    .rdata (rd1)
  );

  // registers, counters and forward flag
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_cols    <= GRID_COLS_RST;
      grid_rows    <= GRID_ROWS_RST;
      row_index    <= '0;
      col_index    <= '0;
      store_select <= 1'b0;
      fwd_hit      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GRID_COLS: grid_cols <= cfg_data[CFG_COLS_W-1:0];
          REG_GRID_ROWS: grid_rows <= cfg_data[CFG_ROWS_W-1:0];
          default: ;
        endcase
      end
      row_index    <= row_index_next;
      col_index    <= col_index_next;
      store_select <= store_select_next;
      // a two-wide row reads column 1 of the store in the cycle it is written
      fwd_hit      <= cell_step && (store_select != store_select_next) &&
                      (col_index == col_next_p1);
    end
  end

  // window payload
  always_ff @(posedge clk) begin
    fwd_data <= sample;
    if (step) begin
      win_left <= self_v;
      win_self <= right_v;
    end
    if (cell_step && col_first) begin
      pend_n0 <= sample;
    end
    if (cell_step && last_col) begin
      hold_n0 <= col_first ? sample : pend_n0;
    end
  end

  // output register with skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (emit) begin
      if (!out_valid || m_tready) begin
        out_valid     <= 1'b1;
        out_value     <= res_value;
        out_row_end   <= last_col;
        out_frame_end <= res_frame_end;
      end else begin
        skid_valid     <= 1'b1;
        skid_value     <= res_value;
        skid_row_end   <= last_col;
        skid_frame_end <= res_frame_end;
      end
    end else if (out_valid && m_tready) begin
      if (skid_valid) begin
        skid_valid    <= 1'b0;
        out_value     <= skid_value;
        out_row_end   <= skid_row_end;
        out_frame_end <= skid_frame_end;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = TDATA_W'(out_value);
  assign m_tlast  = out_row_end;
  assign m_tuser  = out_frame_end;

endmodule

### rtl/jsce_ram.sv
// generic single write port, single read port ram with registered read
module jsce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/jsce_checker.sv
// port-level checks for the jacobi stencil block, bound to the top level
module jsce_checker
  import jsce_pkg::*;
#(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  localparam int TDATA_W    = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input logic               clk,
  input logic               rst,
  input logic               s_tready,
  input logic               m_tvalid,
  input logic               m_tready,
  input logic [TDATA_W-1:0] m_tdata,
  input logic               m_tlast,
  input logic               m_tuser,
  input logic               cfg_ready
);

  // a waiting result holds still
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast) &&
                              $stable(m_tuser))
    else $error("result changed while stalled");

  // the frame end is always also a row end
  a_frame_row: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("frame end without row end");

  // with the output empty the skid stage is empty too, so requests flow
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("request stalled with empty output");

  // after a reset cycle nothing is pending and requests are taken
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready && cfg_ready)
    else $error("output not clear after reset");

endmodule

bind jacobi_stencil_clamped_edges jsce_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_jsce_checker (.*);
